### rtl/sbt_pkg.sv
// Shared types and constants of the sparse bitset table.
package sbt_pkg;

  localparam int MaxChunks = 64;
  localparam int KeyW      = 16;
  localparam int WordW     = 16;
  localparam int BitSelW   = 4;
  localparam int IndexW    = KeyW + BitSelW;
  localparam int IdxW      = (MaxChunks > 1) ? $clog2(MaxChunks) : 1;
  localparam int CntW      = $clog2(MaxChunks + 1);
  localparam int CountOutW = 7;

  typedef enum logic [1:0] {
    OpTest  = 2'd0,
    OpSet   = 2'd1,
    OpClear = 2'd2,
    OpNop   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StSrchRd,
    StSrchCmp,
    StAct,
    StInsRd,
    StInsWr,
    StRemRd,
    StRemWr,
    StDone
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [WordW-1:0] word;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

### rtl/sbt_store.sv
// Chunk table storage: one write port and one registered read port.
module sbt_store (
  input  logic              clk_i,
  input  sbt_pkg::mem_req_t req_i,
  output sbt_pkg::entry_t   rdata_o
);
  import sbt_pkg::*;

  entry_t mem_q [MaxChunks];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sparse_bitset_table_core.sv
// Sparse bitset kept as a sorted table of chunk keys with 16-bit words.
//
// Each transfer tests, sets or clears one bit; bit_index_i[19:4] is the chunk key and
// bit_index_i[3:0] the bit in that chunk's word. One sequencer walks the table, which
// sits in a memory with one write port and one registered read port, so every entry
// takes a read state and then a compare or write state: a search steps over the stored
// chunks below the key, and an insert or a removal then moves each later entry one
// place. The input is stalled while an item is in work; a finished result waits
// in the output register and does not block the next input transfer. The table
// starts empty after reset and needs no clearing pass.
module sparse_bitset_table_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [sbt_pkg::IndexW-1:0]   bit_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         bit_value_o,
  output logic                         table_full_o,
  output logic [sbt_pkg::CountOutW-1:0] chunk_count_o
);
  import sbt_pkg::*;

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [BitSelW-1:0]  bsel_q, bsel_d;
  logic [CntW-1:0]     pos_q, pos_d;
  logic [CntW-1:0]     sh_q, sh_d;
  logic [CntW-1:0]     used_q, used_d;
  logic                found_q, found_d;
  logic [WordW-1:0]    word_q, word_d;
  logic                res_value_q, res_value_d;
  logic                res_full_q, res_full_d;
  logic                out_valid_q, out_valid_d;
  logic                out_value_q, out_value_d;
  logic                out_full_q, out_full_d;
  logic [CntW-1:0]     out_count_q, out_count_d;

  mem_req_t            mem_req;
  entry_t              rdata;
  logic [WordW-1:0]    mask;
  logic [WordW-1:0]    clr_word;
  logic                in_xfer;
  logic                out_free;

  sbt_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign mask     = WordW'(1) << bsel_q;
  assign clr_word = word_q & ~mask;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StSrchRd;
        end
      end
      StSrchRd: begin
        state_d = (pos_q == used_q) ? StAct : StSrchCmp;
      end
      StSrchCmp: begin
        state_d = (rdata.key < key_q) ? StSrchRd : StAct;
      end
      StAct: begin
        state_d = StDone;
        if (op_q == OpSet && !found_q && used_q != CntW'(MaxChunks)) begin
          state_d = StInsRd;
        end else if (op_q == OpClear && found_q && clr_word == '0) begin
          state_d = StRemRd;
        end
      end
      StInsRd: begin
        state_d = (sh_q == pos_q) ? StDone : StInsWr;
      end
      StInsWr: begin
        state_d = StInsRd;
      end
      StRemRd: begin
        state_d = (sh_q + CntW'(1) >= used_q) ? StDone : StRemWr;
      end
      StRemWr: begin
        state_d = StRemRd;
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs of the sequencer: memory requests and datapath register updates.
  always_comb begin
    mem_req       = '0;
    in_stall_o    = 1'b1;
    op_d          = op_q;
    key_d         = key_q;
    bsel_d        = bsel_q;
    pos_d         = pos_q;
    sh_d          = sh_q;
    used_d        = used_q;
    found_d       = found_q;
    word_d        = word_q;
    res_value_d   = res_value_q;
    res_full_d    = res_full_q;
    out_valid_d   = out_valid_q;
    out_value_d   = out_value_q;
    out_full_d    = out_full_q;
    out_count_d   = out_count_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_xfer) begin
          op_d        = op_e'(opcode_i);
          key_d       = bit_index_i[IndexW-1:BitSelW];
          bsel_d      = bit_index_i[BitSelW-1:0];
          pos_d       = '0;
          found_d     = 1'b0;
          res_value_d = 1'b0;
          res_full_d  = 1'b0;
        end
      end
      StSrchRd: begin
        if (pos_q != used_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = pos_q[IdxW-1:0];
        end
      end
      StSrchCmp: begin
        if (rdata.key < key_q) begin
          pos_d = pos_q + CntW'(1);
        end else begin
          found_d = (rdata.key == key_q);
          word_d  = rdata.word;
        end
      end
      StAct: begin
        case (op_q)
          OpTest: begin
            res_value_d = found_q && ((word_q & mask) != '0);
          end
          OpSet: begin
            if (found_q) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = pos_q[IdxW-1:0];
              mem_req.wdata = '{key: key_q, word: word_q | mask};
            end else if (used_q == CntW'(MaxChunks)) begin
              res_full_d = 1'b1;
            end else begin
              sh_d = used_q;
            end
          end
          OpClear: begin
            if (found_q) begin
              if (clr_word != '0) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_q[IdxW-1:0];
                mem_req.wdata = '{key: key_q, word: clr_word};
              end else begin
                sh_d = pos_q;
              end
            end
          end
          default: begin
          end
        endcase
      end
      StInsRd: begin
        if (sh_q == pos_q) begin
          // Every later entry has moved up; the new chunk takes the freed place.
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_q[IdxW-1:0];
          mem_req.wdata = '{key: key_q, word: mask};
          used_d        = used_q + CntW'(1);
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = IdxW'(sh_q - CntW'(1));
        end
      end
      StInsWr: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sh_q[IdxW-1:0];
        mem_req.wdata = rdata;
        sh_d          = sh_q - CntW'(1);
      end
      StRemRd: begin
        if (sh_q + CntW'(1) >= used_q) begin
          used_d = used_q - CntW'(1);
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = IdxW'(sh_q + CntW'(1));
        end
      end
      StRemWr: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sh_q[IdxW-1:0];
        mem_req.wdata = rdata;
        sh_d          = sh_q + CntW'(1);
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = res_value_q;
          out_full_d  = res_full_q;
          out_count_d = used_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    bsel_q      <= bsel_d;
    pos_q       <= pos_d;
    sh_q        <= sh_d;
    found_q     <= found_d;
    word_q      <= word_d;
    res_value_q <= res_value_d;
    res_full_q  <= res_full_d;
    out_value_q <= out_value_d;
    out_full_q  <= out_full_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign bit_value_o   = out_value_q;
  assign table_full_o  = out_full_q;
  assign chunk_count_o = CountOutW'(out_count_q);

endmodule
